// ===== hdl/fjt_pkg.sv =====
// ----------------------------------------------------------------------------
// fjt_pkg
// Shared types, codes and helpers of the flat JSON pair tokenizer.
// ----------------------------------------------------------------------------
package fjt_pkg;

  localparam int FJT_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_KEY_ERR   = 3'd1;
  localparam logic [2:0] ST_NO_COLON  = 3'd2;
  localparam logic [2:0] ST_VAL_ERR   = 3'd3;
  localparam logic [2:0] ST_EMPTY_OBJ = 3'd4;
  localparam logic [2:0] ST_EMPTY_TXT = 3'd5;

  localparam logic [1:0] CK_NONE  = 2'd0;
  localparam logic [1:0] CK_KEY   = 2'd1;
  localparam logic [1:0] CK_VALUE = 2'd2;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_OPEN     = 4'd1,
    PH_MAIN     = 4'd2,
    PH_KEY      = 4'd3,
    PH_KEY_ESC  = 4'd4,
    PH_COLON    = 4'd5,
    PH_VAL_WAIT = 4'd6,
    PH_BARE     = 4'd7,
    PH_VSTR     = 4'd8,
    PH_VSTR_ESC = 4'd9,
    PH_DONE     = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_SPACE  = 3'd1,
    CLS_QUOTE  = 3'd2,
    CLS_BSLASH = 3'd3,
    CLS_LBRACE = 3'd4,
    CLS_RBRACE = 3'd5,
    CLS_COLON  = 3'd6,
    CLS_COMMA  = 3'd7
  } cls_t;

  typedef struct packed {
    logic       func;
    logic [7:0] text_byte;
    cls_t       cls;
  } item_t;

  typedef struct packed {
    logic [1:0] char_kind;
    logic [7:0] out_char;
    logic       key_end;
    logic       value_end;
    logic       text_done;
    logic [2:0] status;
  } result_t;

  // Handshake between the front queue and the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } front_out_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    k = CLS_OTHER;
    if (c inside {8'h20, [8'h09:8'h0D]}) begin
      k = CLS_SPACE;
    end else begin
      case (c)
        CH_QUOTE:  k = CLS_QUOTE;
        CH_BSLASH: k = CLS_BSLASH;
        CH_LBRACE: k = CLS_LBRACE;
        CH_RBRACE: k = CLS_RBRACE;
        CH_COLON:  k = CLS_COLON;
        CH_COMMA:  k = CLS_COMMA;
        default:   k = CLS_OTHER;
      endcase
    end
    return k;
  endfunction

endpackage

// ===== hdl/fjt_fifo.sv =====
// ----------------------------------------------------------------------------
// fjt_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module fjt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2   // at least 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/fjt_front.sv =====
// ----------------------------------------------------------------------------
// fjt_front
// Accepts input transactions, classifies each byte and queues it for the
// back end.
// ----------------------------------------------------------------------------
module fjt_front import fjt_pkg::*; #(
  parameter int QUEUE_DEPTH = FJT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       func,
  input  logic [7:0] text_byte,
  output logic       full,
  input  logic       take,
  output front_out_t front_out
);

  item_t in_item;
  item_t q_item;
  logic  q_empty;

  always_comb begin
    in_item.func      = func;
    in_item.text_byte = text_byte;
    in_item.cls       = classify(text_byte);
  end

  fjt_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (in_item),
    .full    (full),
    .rd_en   (take),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  assign front_out.valid = !q_empty;
  assign front_out.item  = q_item;

endmodule

// ===== hdl/fjt_back.sv =====
// ----------------------------------------------------------------------------
// fjt_back
// Scanner state machine: turns classified bytes into key and value
// characters and end markers, and queues one result per item.
// ----------------------------------------------------------------------------
module fjt_back import fjt_pkg::*; #(
  parameter int QUEUE_DEPTH = FJT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  front_out_t front_out,
  output logic       take,
  input  logic       pop,
  output logic       empty,
  output result_t    result
);

  phase_t     phase;
  phase_t     phase_next;
  logic       seen_byte;
  logic       seen_byte_next;
  logic [2:0] latched_status;
  logic [2:0] latched_status_next;
  result_t    res;
  logic       res_full;
  item_t      it;
  logic       is_space;
  logic       is_sep;

  assign it       = front_out.item;
  assign take     = front_out.valid && !res_full;
  assign is_space = (it.cls == CLS_SPACE);
  assign is_sep   = (it.cls == CLS_COMMA) || (it.cls == CLS_RBRACE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      seen_byte      <= 1'b0;
      latched_status <= ST_OK;
    end else if (take) begin
      phase          <= phase_next;
      seen_byte      <= seen_byte_next;
      latched_status <= latched_status_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    seen_byte_next      = seen_byte;
    latched_status_next = latched_status;
    res                 = '0;
    if (it.func == FUNC_END) begin
      res.text_done = 1'b1;
      case (phase)
        PH_START, PH_OPEN: res.status = seen_byte ? ST_OK : ST_EMPTY_TXT;
        PH_KEY, PH_KEY_ESC: res.status = ST_KEY_ERR;
        PH_COLON: res.status = ST_NO_COLON;
        PH_VAL_WAIT, PH_BARE: res.value_end = 1'b1;
        PH_VSTR, PH_VSTR_ESC: res.status = ST_VAL_ERR;
        PH_DONE: res.status = latched_status;
        default: res.status = ST_OK;
      endcase
      // The end of text returns the scanner to its reset state.
      phase_next          = PH_START;
      seen_byte_next      = 1'b0;
      latched_status_next = ST_OK;
    end else begin
      seen_byte_next = 1'b1;
      case (phase)
        PH_START: begin
          if (it.cls == CLS_LBRACE) phase_next = PH_OPEN;
          else if (it.cls == CLS_QUOTE) phase_next = PH_KEY;
          else if (!is_space) phase_next = PH_MAIN;
        end
        PH_OPEN: begin
          if (it.cls == CLS_RBRACE) begin
            latched_status_next = ST_EMPTY_OBJ;
            phase_next          = PH_DONE;
          end else if (it.cls == CLS_QUOTE) begin
            phase_next = PH_KEY;
          end else if (!is_space) begin
            phase_next = PH_MAIN;
          end
        end
        PH_KEY: begin
          if (it.cls == CLS_QUOTE) begin
            res.key_end = 1'b1;
            phase_next  = PH_COLON;
          end else if (it.cls == CLS_BSLASH) begin
            phase_next = PH_KEY_ESC;
          end else begin
            res.char_kind = CK_KEY;
            res.out_char  = it.text_byte;
          end
        end
        PH_KEY_ESC: begin
          res.char_kind = CK_KEY;
          res.out_char  = it.text_byte;
          phase_next    = PH_KEY;
        end
        PH_COLON: begin
          if (it.cls == CLS_COLON) begin
            phase_next = PH_VAL_WAIT;
          end else if (!is_space) begin
            latched_status_next = ST_NO_COLON;
            phase_next          = PH_DONE;
          end
        end
        PH_VAL_WAIT: begin
          if (it.cls == CLS_QUOTE) begin
            phase_next = PH_VSTR;
          end else if (is_sep) begin
            // A separator right away closes an empty bare value.
            res.value_end = 1'b1;
            phase_next    = PH_MAIN;
          end else if (!is_space) begin
            res.char_kind = CK_VALUE;
            res.out_char  = it.text_byte;
            phase_next    = PH_BARE;
          end
        end
        PH_BARE: begin
          if (is_sep) begin
            res.value_end = 1'b1;
            phase_next    = PH_MAIN;
          end else if (!is_space) begin
            res.char_kind = CK_VALUE;
            res.out_char  = it.text_byte;
          end
        end
        PH_VSTR: begin
          if (it.cls == CLS_QUOTE) begin
            res.value_end = 1'b1;
            phase_next    = PH_MAIN;
          end else if (it.cls == CLS_BSLASH) begin
            phase_next = PH_VSTR_ESC;
          end else begin
            res.char_kind = CK_VALUE;
            res.out_char  = it.text_byte;
          end
        end
        PH_VSTR_ESC: begin
          res.char_kind = CK_VALUE;
          res.out_char  = it.text_byte;
          phase_next    = PH_VSTR;
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          // Between pairs, and any unused phase code.
          phase_next = (it.cls == CLS_QUOTE) ? PH_KEY : PH_MAIN;
        end
      endcase
    end
  end

  fjt_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

// ===== hdl/flat_json_pair_tokenizer.sv =====
// ----------------------------------------------------------------------------
// flat_json_pair_tokenizer
// Streaming tokenizer for the keys and values of a flat JSON object.
// ----------------------------------------------------------------------------
// Each input transaction carries one text byte or, with func high, the end of
// the text; each yields exactly one result transaction carrying a key or value
// character, key and value end marks, and on the end item the text status.
// The block sustains one item per clock while neither queue is full and the
// consumer pops: a front queue holds classified bytes, the scanner updates
// its phase once for each item it takes, and a result queue of QUEUE_DEPTH
// entries decouples it from the consumer. An accepted item is registered in
// the front queue and then in the result queue before it reaches the outputs.
module flat_json_pair_tokenizer import fjt_pkg::*; #(
  parameter int QUEUE_DEPTH = FJT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       func,
  input  logic [7:0] text_byte,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] char_kind,
  output logic [7:0] out_char,
  output logic       key_end,
  output logic       value_end,
  output logic       text_done,
  output logic [2:0] status
);

  front_out_t front_out;
  logic       take;
  result_t    result;

  fjt_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .func      (func),
    .text_byte (text_byte),
    .full      (full),
    .take      (take),
    .front_out (front_out)
  );

  fjt_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .front_out (front_out),
    .take      (take),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign char_kind = result.char_kind;
  assign out_char  = result.out_char;
  assign key_end   = result.key_end;
  assign value_end = result.value_end;
  assign text_done = result.text_done;
  assign status    = result.status;

`ifndef SYNTH
  // The result queue is empty in the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty) else $error("result queue not empty after reset");

  // The end item never carries a character or a key end.
  a_done_alone: assert property (@(posedge clk) disable iff (rst)
    (!empty && text_done) |-> (char_kind == CK_NONE && !key_end))
    else $error("end-of-text result carries a character");

  // A status is only reported on the end item.
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && !text_done) |-> (status == ST_OK))
    else $error("status reported without end of text");

  // A key end is a closing quote and never a character.
  a_key_end_alone: assert property (@(posedge clk) disable iff (rst)
    (!empty && key_end) |-> (char_kind == CK_NONE && !value_end))
    else $error("key end combined with other output");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the flat JSON pair tokenizer. A directed set covers
// the status codes and edge bytes, then randomly built objects (mostly
// well-formed, some cut short, corrupted or pure noise) are streamed with
// random gaps on both sides. A scoreboard predicts every result transaction
// and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import fjt_pkg::*;

  class token_scoreboard;
    phase_t     phase = PH_START;
    bit         seen_text = 1'b0;
    logic [2:0] held_status = ST_OK;
    result_t    expected_tokens[$];
    int         mismatches = 0;

    function bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Works out the result transaction for one accepted item.
    function void predict_token(logic fn, logic [7:0] c);
      result_t r;
      r = '0;
      if (fn == FUNC_END) begin
        r.text_done = 1'b1;
        case (phase)
          PH_START, PH_OPEN: r.status = seen_text ? ST_OK : ST_EMPTY_TXT;
          PH_KEY, PH_KEY_ESC: r.status = ST_KEY_ERR;
          PH_COLON: r.status = ST_NO_COLON;
          PH_VAL_WAIT, PH_BARE: r.value_end = 1'b1;
          PH_VSTR, PH_VSTR_ESC: r.status = ST_VAL_ERR;
          PH_DONE: r.status = held_status;
          default: r.status = ST_OK;
        endcase
        phase = PH_START;
        seen_text = 1'b0;
        held_status = ST_OK;
      end else begin
        seen_text = 1'b1;
        case (phase)
          PH_START: begin
            if (c == CH_LBRACE) phase = PH_OPEN;
            else if (c == CH_QUOTE) phase = PH_KEY;
            else if (!is_blank(c)) phase = PH_MAIN;
          end
          PH_OPEN: begin
            if (c == CH_RBRACE) begin
              held_status = ST_EMPTY_OBJ;
              phase = PH_DONE;
            end else if (c == CH_QUOTE) begin
              phase = PH_KEY;
            end else if (!is_blank(c)) begin
              phase = PH_MAIN;
            end
          end
          PH_KEY: begin
            if (c == CH_QUOTE) begin
              r.key_end = 1'b1;
              phase = PH_COLON;
            end else if (c == CH_BSLASH) begin
              phase = PH_KEY_ESC;
            end else begin
              r.char_kind = CK_KEY;
              r.out_char = c;
            end
          end
          PH_KEY_ESC: begin
            r.char_kind = CK_KEY;
            r.out_char = c;
            phase = PH_KEY;
          end
          PH_COLON: begin
            if (c == CH_COLON) begin
              phase = PH_VAL_WAIT;
            end else if (!is_blank(c)) begin
              held_status = ST_NO_COLON;
              phase = PH_DONE;
            end
          end
          PH_VAL_WAIT: begin
            if (!is_blank(c)) begin
              if (c == CH_QUOTE) begin
                phase = PH_VSTR;
              end else if (c == CH_COMMA || c == CH_RBRACE) begin
                r.value_end = 1'b1;
                phase = PH_MAIN;
              end else begin
                r.char_kind = CK_VALUE;
                r.out_char = c;
                phase = PH_BARE;
              end
            end
          end
          PH_BARE: begin
            if (c == CH_COMMA || c == CH_RBRACE) begin
              r.value_end = 1'b1;
              phase = PH_MAIN;
            end else if (!is_blank(c)) begin
              r.char_kind = CK_VALUE;
              r.out_char = c;
            end
          end
          PH_VSTR: begin
            if (c == CH_QUOTE) begin
              r.value_end = 1'b1;
              phase = PH_MAIN;
            end else if (c == CH_BSLASH) begin
              phase = PH_VSTR_ESC;
            end else begin
              r.char_kind = CK_VALUE;
              r.out_char = c;
            end
          end
          PH_VSTR_ESC: begin
            r.char_kind = CK_VALUE;
            r.out_char = c;
            phase = PH_VSTR;
          end
          PH_DONE: begin
          end
          default: begin
            phase = (c == CH_QUOTE) ? PH_KEY : PH_MAIN;
          end
        endcase
      end
      expected_tokens.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_token(result_t got);
      result_t want;
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", got));
        return;
      end
      want = expected_tokens.pop_front();
      if (got.char_kind !== want.char_kind)
        report_mismatch($sformatf("char_kind %0d, expected %0d", got.char_kind, want.char_kind));
      if (got.out_char !== want.out_char)
        report_mismatch($sformatf("out_char %h, expected %h", got.out_char, want.out_char));
      if (got.key_end !== want.key_end)
        report_mismatch($sformatf("key_end %b, expected %b", got.key_end, want.key_end));
      if (got.value_end !== want.value_end)
        report_mismatch($sformatf("value_end %b, expected %b", got.value_end, want.value_end));
      if (got.text_done !== want.text_done)
        report_mismatch($sformatf("text_done %b, expected %b", got.text_done, want.text_done));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask
  endclass

  localparam int IDLE_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       func = FUNC_BYTE;
  logic [7:0] text_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] char_kind;
  logic [7:0] out_char;
  logic       key_end;
  logic       value_end;
  logic       text_done;
  logic [2:0] status;

  token_scoreboard tokens;
  int              items_sent = 0;
  int              idle_cycles = 0;
  bit              send_calm = 1'b0;
  bit              take_calm = 1'b0;
  logic [7:0]      json_bytes[$];
  logic [7:0]      blank_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  logic [7:0]      punct_set[6] = '{CH_QUOTE, CH_BSLASH, CH_LBRACE, CH_RBRACE,
                                    CH_COLON, CH_COMMA};

  flat_json_pair_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .func      (func),
    .text_byte (text_byte),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .char_kind (char_kind),
    .out_char  (out_char),
    .key_end   (key_end),
    .value_end (value_end),
    .text_done (text_done),
    .status    (status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_item(logic fn, logic [7:0] c);
    int gap;
    if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func <= fn;
    text_byte <= c;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    tokens.predict_token(fn, c);
    items_sent++;
    @(negedge clk);
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(FUNC_BYTE, s[i]);
  endtask

  task end_text();
    send_item(FUNC_END, 8'($urandom));
  endtask

  function logic [7:0] any_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function void add_blanks();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) json_bytes.push_back(blank_set[$urandom_range(0, 5)]);
  endfunction

  // Quoted key or value; quotes and backslashes inside are always escaped.
  function void add_quoted();
    int n;
    logic [7:0] c;
    n = $urandom_range(0, 4);
    json_bytes.push_back(CH_QUOTE);
    repeat (n) begin
      c = any_byte();
      if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(0, 7) == 0)
        json_bytes.push_back(CH_BSLASH);
      json_bytes.push_back(c);
    end
    json_bytes.push_back(CH_QUOTE);
  endfunction

  function void add_bare();
    int n;
    logic [7:0] c;
    n = $urandom_range(0, 4);
    repeat (n) begin
      c = any_byte();
      if (c != CH_COMMA && c != CH_RBRACE && c != CH_QUOTE) json_bytes.push_back(c);
      if ($urandom_range(0, 3) == 0) json_bytes.push_back(blank_set[$urandom_range(0, 5)]);
    end
  endfunction

  function void build_object();
    int pairs;
    json_bytes.delete();
    add_blanks();
    if ($urandom_range(0, 5) != 0) json_bytes.push_back(CH_LBRACE);
    pairs = $urandom_range(1, 4);
    for (int i = 0; i < pairs; i++) begin
      add_blanks();
      add_quoted();
      add_blanks();
      json_bytes.push_back(CH_COLON);
      add_blanks();
      if ($urandom_range(0, 1) == 0) add_quoted();
      else add_bare();
      add_blanks();
      if (i < pairs - 1) json_bytes.push_back(CH_COMMA);
    end
    if ($urandom_range(0, 4) != 0) json_bytes.push_back(CH_RBRACE);
    add_blanks();
  endfunction

  initial begin
    int mode;
    int n;
    int cut;
    tokens = new;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every end status, the edge bytes, escapes at the end of text.
    end_text();
    send_text("{}x");
    end_text();
    send_text(" ");
    end_text();
    send_item(FUNC_BYTE, CH_QUOTE);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, CH_BSLASH);
    end_text();
    send_text("\"\"x");
    end_text();
    send_item(FUNC_BYTE, CH_QUOTE);
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_BYTE, CH_QUOTE);
    end_text();
    send_text("\"\":");
    end_text();
    send_text("\"\":\"\\");
    end_text();

    // Random texts: mostly well-formed, some cut short, corrupted or noise.
    while (items_sent < 1200) begin
      mode = $urandom_range(0, 19);
      build_object();
      if (mode < 3) begin
        json_bytes.delete();
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) json_bytes.push_back(8'($urandom_range(0, 255)));
          else json_bytes.push_back(punct_set[$urandom_range(0, 5)]);
        end
      end else if (mode < 5) begin
        json_bytes[$urandom_range(0, json_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (mode < 8) begin
        cut = $urandom_range(0, json_bytes.size());
        while (json_bytes.size() > cut) void'(json_bytes.pop_back());
      end
      foreach (json_bytes[i]) send_item(FUNC_BYTE, json_bytes[i]);
      end_text();
    end
    push <= 1'b0;

    while (tokens.expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tokens.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random pop stalls, sampled at the rising edge.
  initial begin
    int gap;
    result_t got;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) take_calm = ~take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.char_kind = char_kind;
      got.out_char = out_char;
      got.key_end = key_end;
      got.value_end = value_end;
      got.text_done = text_done;
      got.status = status;
      tokens.check_token(got);
      @(negedge clk);
    end
  end

  // Ends the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
